// ===== src/clt_pkg.sv =====
// Shared types, codes and packet builders for the chunked line transfer receiver.
package clt_pkg;

  localparam int IDLE_POLL_LIMIT_DEF = 25;
  localparam int RESEND_INTERVAL_DEF = 5;
  localparam int IDLE_W = 5;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = 2;
  localparam int OQ_CNT_W = 3;

  typedef enum logic [2:0] {
    EV_BEGIN  = 3'd0,
    EV_PACKET = 3'd1,
    EV_POLL   = 3'd2,
    EV_XPORT  = 3'd3,
    EV_TICK   = 3'd4
  } ev_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TIMEOUT = 3'd1,
    ST_XPORT   = 3'd2,
    ST_CANCEL  = 3'd3,
    ST_PROTO   = 3'd4,
    ST_INVALID = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    PH_START = 2'd0,
    PH_VIEW  = 2'd1,
    PH_DATA  = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    REG_START_CODE  = 3'd0,
    REG_VIEW_CODE   = 3'd1,
    REG_DATA_CODE   = 3'd2,
    REG_END_CODE    = 3'd3,
    REG_CANCEL_CODE = 3'd4,
    REG_MAX_CHUNK   = 3'd5,
    REG_SEND_END    = 3'd6,
    REG_TIMEOUT     = 3'd7
  } reg_idx_t;

  localparam logic [2:0] LEN_NONE = 3'd0;
  localparam logic [2:0] LEN_DATA = 3'd4;
  localparam logic [2:0] LEN_VIEW = 3'd6;
  localparam logic [15:0] PKT_LEN_VIEW = 16'd6;
  localparam logic [15:0] PKT_LEN_HDR = 16'd4;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  pkt_type;
    logic [15:0] pkt_length;
    logic [31:0] pkt_word;
    logic [15:0] pkt_limit;
    logic [31:0] lines_stored;
    logic        lines_complete_ok;
  } in_t;

  typedef struct packed {
    logic        out_kind;
    logic [7:0]  send_type;
    logic [2:0]  send_length;
    logic [31:0] send_word;
    logic [15:0] send_limit;
    logic [2:0]  status;
    logic        last;
  } out_t;

  typedef struct packed {
    logic [7:0]  start_code;
    logic [7:0]  view_code;
    logic [7:0]  data_code;
    logic [7:0]  end_code;
    logic [7:0]  cancel_code;
    logic [15:0] max_chunk_bytes;
    logic        send_end_on_success;
    logic [15:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0] n;
    out_t       r0;
    out_t       r1;
  } push_t;

  function automatic out_t mk_pkt(logic [7:0] typ, logic [2:0] len, logic [31:0] word,
                                  logic [15:0] lim);
    out_t o;
    o = '0;
    o.send_type = typ;
    o.send_length = len;
    o.send_word = word;
    o.send_limit = lim;
    return o;
  endfunction

  function automatic out_t mk_stat(status_t st);
    out_t o;
    o = '0;
    o.out_kind = 1'b1;
    o.status = st;
    return o;
  endfunction

  function automatic push_t push_one(out_t a);
    push_t p;
    p = '0;
    p.n = 2'd1;
    p.r0 = a;
    p.r0.last = 1'b1;
    return p;
  endfunction

  function automatic push_t push_two(out_t a, out_t b);
    push_t p;
    p = '0;
    p.n = 2'd2;
    p.r0 = a;
    p.r1 = b;
    p.r1.last = 1'b1;
    return p;
  endfunction

  function automatic push_t fail_push(cfg_t c, status_t st);
    return push_two(mk_pkt(c.cancel_code, LEN_NONE, '0, '0), mk_stat(st));
  endfunction

  function automatic push_t succeed_push(cfg_t c, logic complete);
    push_t p;
    if (!complete) begin
      p = fail_push(c, ST_INVALID);
    end else if (c.send_end_on_success) begin
      p = push_two(mk_pkt(c.end_code, LEN_NONE, '0, '0), mk_stat(ST_OK));
    end else begin
      p = push_one(mk_stat(ST_OK));
    end
    return p;
  endfunction

  function automatic out_t req_pkt(cfg_t c, phase_t ph, logic [31:0] line);
    out_t o;
    unique case (ph)
      PH_START: o = mk_pkt(c.start_code, LEN_NONE, '0, '0);
      PH_VIEW:  o = mk_pkt(c.view_code, LEN_VIEW, '0, c.max_chunk_bytes);
      default:  o = mk_pkt(c.data_code, LEN_DATA, line, '0);
    endcase
    return o;
  endfunction

endpackage

// ===== src/clt_cfg.sv =====
// Configuration register file with write port.
module clt_cfg (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output clt_pkg::cfg_t cfg
);
  import clt_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_code <= 8'd1;
      cfg.view_code <= 8'd2;
      cfg.data_code <= 8'd3;
      cfg.end_code <= 8'd4;
      cfg.cancel_code <= 8'd5;
      cfg.max_chunk_bytes <= 16'd512;
      cfg.send_end_on_success <= 1'b1;
      cfg.timeout_ms <= 16'd2500;
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_START_CODE:  cfg.start_code <= cfg_data[7:0];
        REG_VIEW_CODE:   cfg.view_code <= cfg_data[7:0];
        REG_DATA_CODE:   cfg.data_code <= cfg_data[7:0];
        REG_END_CODE:    cfg.end_code <= cfg_data[7:0];
        REG_CANCEL_CODE: cfg.cancel_code <= cfg_data[7:0];
        REG_MAX_CHUNK:   cfg.max_chunk_bytes <= cfg_data;
        REG_SEND_END:    cfg.send_end_on_success <= cfg_data[0];
        REG_TIMEOUT:     cfg.timeout_ms <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/clt_core.sv =====
// Input register, transfer state and per-event result logic.
module clt_core #(
  parameter int IDLE_POLL_LIMIT = clt_pkg::IDLE_POLL_LIMIT_DEF,
  parameter int RESEND_INTERVAL = clt_pkg::RESEND_INTERVAL_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  clt_pkg::in_t   req,
  input  clt_pkg::cfg_t  cfg,
  input  logic           space2,
  output clt_pkg::push_t push
);
  import clt_pkg::*;

  localparam int PW = $clog2(RESEND_INTERVAL + 1);

  in_t              in_reg;
  logic             in_full;
  logic             process;

  logic             active, active_next;
  phase_t           phase, phase_next;
  logic [31:0]      line_count, line_count_next;
  logic [31:0]      req_line, req_line_next;
  logic [15:0]      chunk_limit, chunk_limit_next;
  logic [IDLE_W-1:0] idle_polls, idle_polls_next;
  logic [PW-1:0]    poll_phase, poll_phase_next;
  logic [15:0]      elapsed_ms, elapsed_ms_next;
  push_t            res;

  logic             code_hit;
  logic [15:0]      lim_eff;
  logic [16:0]      len_max;
  logic [31:0]      done_lines;
  logic [31:0]      remain;
  logic [31:0]      end_line;
  logic [IDLE_W:0]  poll_cnt;
  logic [15:0]      elapsed_inc;

  assign process = in_full && space2;
  assign req_stall = in_full && !space2;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (req_valid && !req_stall) begin
      in_full <= 1'b1;
    end else if (process) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      in_reg <= req;
    end
  end

  assign code_hit = (in_reg.pkt_type == cfg.start_code) || (in_reg.pkt_type == cfg.view_code) ||
                    (in_reg.pkt_type == cfg.data_code) || (in_reg.pkt_type == cfg.end_code) ||
                    (in_reg.pkt_type == cfg.cancel_code);
  assign lim_eff = (in_reg.pkt_length == PKT_LEN_VIEW) ? in_reg.pkt_limit : 16'd0;
  assign len_max = {1'b0, chunk_limit} + 17'd4;
  assign done_lines = req_line - 32'd1;
  assign remain = line_count - done_lines;
  assign end_line = done_lines + in_reg.lines_stored;
  assign poll_cnt = {1'b0, idle_polls} + {{IDLE_W{1'b0}}, 1'b1};
  assign elapsed_inc = (elapsed_ms != 16'hFFFF) ? elapsed_ms + 16'd1 : elapsed_ms;

  always_comb begin
    active_next = active;
    phase_next = phase;
    line_count_next = line_count;
    req_line_next = req_line;
    chunk_limit_next = chunk_limit;
    idle_polls_next = idle_polls;
    poll_phase_next = poll_phase;
    elapsed_ms_next = elapsed_ms;
    res = '0;
    if (process) begin
      case (in_reg.req_type)
        EV_BEGIN: begin
          active_next = 1'b1;
          phase_next = PH_START;
          line_count_next = '0;
          req_line_next = 32'd1;
          chunk_limit_next = '0;
          idle_polls_next = '0;
          poll_phase_next = '0;
          elapsed_ms_next = '0;
          res = push_one(req_pkt(cfg, PH_START, 32'd1));
        end
        EV_PACKET: begin
          if (active && code_hit) begin
            idle_polls_next = '0;
            poll_phase_next = '0;
            if (in_reg.pkt_type == cfg.cancel_code) begin
              res = push_two(mk_pkt(cfg.end_code, LEN_NONE, '0, '0), mk_stat(ST_CANCEL));
            end else begin
              unique case (phase)
                PH_START: begin
                  if (in_reg.pkt_type != cfg.start_code || in_reg.pkt_length != '0) begin
                    res = fail_push(cfg, ST_PROTO);
                  end else begin
                    phase_next = PH_VIEW;
                    res = push_one(req_pkt(cfg, PH_VIEW, req_line));
                  end
                end
                PH_VIEW: begin
                  if (in_reg.pkt_type != cfg.view_code || in_reg.pkt_length != PKT_LEN_VIEW ||
                      lim_eff == '0 || lim_eff > cfg.max_chunk_bytes) begin
                    res = fail_push(cfg, ST_PROTO);
                  end else begin
                    chunk_limit_next = lim_eff;
                    line_count_next = in_reg.pkt_word;
                    if (in_reg.pkt_word == '0) begin
                      res = succeed_push(cfg, in_reg.lines_complete_ok);
                    end else begin
                      phase_next = PH_DATA;
                      res = push_one(req_pkt(cfg, PH_DATA, req_line));
                    end
                  end
                end
                default: begin
                  if (in_reg.pkt_type == cfg.end_code) begin
                    res = fail_push(cfg, ST_PROTO);
                  end else if (in_reg.pkt_type != cfg.data_code ||
                               in_reg.pkt_length <= PKT_LEN_HDR ||
                               {1'b0, in_reg.pkt_length} > len_max) begin
                    res = fail_push(cfg, ST_PROTO);
                  end else if (in_reg.pkt_word != req_line) begin
                    res = fail_push(cfg, ST_PROTO);
                  end else if (in_reg.lines_stored == '0) begin
                    res = fail_push(cfg, ST_INVALID);
                  end else if (in_reg.lines_stored > remain) begin
                    res = fail_push(cfg, ST_PROTO);
                  end else if (end_line == line_count) begin
                    res = succeed_push(cfg, in_reg.lines_complete_ok);
                  end else begin
                    req_line_next = end_line + 32'd1;
                    res = push_one(req_pkt(cfg, PH_DATA, end_line + 32'd1));
                  end
                end
              endcase
            end
          end
        end
        EV_POLL: begin
          if (active) begin
            idle_polls_next = poll_cnt[IDLE_W-1:0];
            if (poll_cnt > (IDLE_W + 1)'(IDLE_POLL_LIMIT)) begin
              res = fail_push(cfg, ST_TIMEOUT);
            end else if (poll_phase == PW'(RESEND_INTERVAL - 1)) begin
              poll_phase_next = '0;
              res = push_one(req_pkt(cfg, phase, req_line));
            end else begin
              poll_phase_next = poll_phase + PW'(1);
            end
          end
        end
        EV_XPORT: begin
          if (active) begin
            res = fail_push(cfg, ST_XPORT);
          end
        end
        EV_TICK: begin
          if (active) begin
            elapsed_ms_next = elapsed_inc;
            if (elapsed_inc >= cfg.timeout_ms) begin
              res = fail_push(cfg, ST_TIMEOUT);
            end
          end
        end
        default: ;
      endcase
      if (res.n == 2'd2 || (res.n == 2'd1 && res.r0.out_kind)) begin
        active_next = 1'b0;
      end
    end
  end

  assign push = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      phase <= PH_START;
      line_count <= '0;
      req_line <= 32'd1;
      chunk_limit <= '0;
      idle_polls <= '0;
      poll_phase <= '0;
      elapsed_ms <= '0;
    end else begin
      active <= active_next;
      phase <= phase_next;
      line_count <= line_count_next;
      req_line <= req_line_next;
      chunk_limit <= chunk_limit_next;
      idle_polls <= idle_polls_next;
      poll_phase <= poll_phase_next;
      elapsed_ms <= elapsed_ms_next;
    end
  end

endmodule

// ===== src/clt_outq.sv =====
// Result queue taking up to two words per cycle and giving one while rsp_stall is low.
module clt_outq (
  input  logic           clk,
  input  logic           rst,
  input  clt_pkg::push_t push,
  output logic           space2,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output clt_pkg::out_t  rsp
);
  import clt_pkg::*;

  out_t                mem [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_ptr;
  logic [OQ_PTR_W-1:0] rd_ptr;
  logic [OQ_CNT_W-1:0] count;
  logic                pop;

  assign rsp_valid = count != '0;
  assign rsp = mem[rd_ptr];
  assign pop = rsp_valid && !rsp_stall;
  assign space2 = count <= OQ_CNT_W'(OQ_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      mem[wr_ptr] <= push.r0;
    end
    if (push.n == 2'd2) begin
      mem[wr_ptr + OQ_PTR_W'(1)] <= push.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + OQ_PTR_W'(push.n);
      if (pop) begin
        rd_ptr <= rd_ptr + OQ_PTR_W'(1);
      end
      count <= count + OQ_CNT_W'(push.n) - OQ_CNT_W'(pop);
    end
  end

endmodule

// ===== src/chunked_line_transfer_receiver.sv =====
// Top level of the chunked line transfer receiver.
//
//   channel | direction | handshake          | word
//   req     | in        | req_valid/req_stall | event: type, packet header, store result
//   rsp     | out       | rsp_valid/rsp_stall | packet to send or final status
//   cfg     | in        | cfg_valid/cfg_ready | register index and data
//
// An event is taken into an input register and resolved once the queue has room for two
// words; its one or two result words enter a four-entry queue whose head drives rsp.
// One event per cycle is sustained while each gives one word and rsp_stall stays low; an
// event with two words needs two reads through the queue's single read port.
// Reset is synchronous; the queue and input register come out empty.
// req_stall rises when the input register holds an event and the queue lacks room for two words.
module chunked_line_transfer_receiver #(
  parameter int IDLE_POLL_LIMIT = clt_pkg::IDLE_POLL_LIMIT_DEF,
  parameter int RESEND_INTERVAL = clt_pkg::RESEND_INTERVAL_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  clt_pkg::in_t  req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output clt_pkg::out_t rsp,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [15:0]   cfg_data
);
  import clt_pkg::*;

  cfg_t  cfg;
  push_t push;
  logic  space2;

  clt_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  clt_core #(
    .IDLE_POLL_LIMIT (IDLE_POLL_LIMIT),
    .RESEND_INTERVAL (RESEND_INTERVAL)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cfg       (cfg),
    .space2    (space2),
    .push      (push)
  );

  clt_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .space2    (space2),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
